// ===== rtl/cszp_pkg.sv =====
// ----------------------------------------------------------------------------
// cszp_pkg
// Shared constants and types for the color score z projection block.
// ----------------------------------------------------------------------------
package cszp_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned PIX_W     = 16;
    localparam int unsigned PLANE_W   = 10;
    localparam int unsigned SCORE_W   = 32;
    localparam int unsigned ENTRY_W   = SCORE_W + PLANE_W;
    localparam int unsigned PIXELS    = 65536;
    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned NUM_W     = 8 + 16 + 16 + FRAC_BITS + 1; // m*n*n*4096
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned QUO_W     = NUM_W;

    // Per-item context carried along the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PLANE_W-1:0] plane;
    } t_ctx;

    // Read-modify-write request into the projection store stage
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        t_ctx               ctx;
    } t_upd;

endpackage

// ===== rtl/cszp_ram.sv =====
// ----------------------------------------------------------------------------
// cszp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cszp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cszp_score.sv =====
// ----------------------------------------------------------------------------
// cszp_score
// Pipelined hue weighted score: clamp, fold, multiply, then a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module cszp_score (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_red,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_green,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_blue,
    input  cszp_pkg::t_ctx               i_ctx,
    output logic                         o_valid,
    output cszp_pkg::t_upd               o_upd
);

    localparam int unsigned NW = cszp_pkg::NUM_W;
    localparam int unsigned DW = cszp_pkg::DEN_W;

    // Stage 1: clamp, weight numerator, denominator, min sample
    logic [7:0]  c_r, c_g, c_b, c_mx;
    logic signed [10:0] c_d, c_n;
    logic r1_v, r1_zero;
    logic [8:0]  r1_n;
    logic [7:0]  r1_d;
    logic [15:0] r1_m;
    cszp_pkg::t_ctx r1_ctx;

    always_comb begin
        c_r  = (i_red   > 16'd255) ? 8'd255 : i_red[7:0];
        c_g  = (i_green > 16'd255) ? 8'd255 : i_green[7:0];
        c_b  = (i_blue  > 16'd255) ? 8'd255 : i_blue[7:0];
        c_mx = (c_r > c_g) ? c_r : c_g;
        c_d  = $signed({3'b0, c_mx}) - $signed({3'b0, c_b});
        c_n  = c_d - $signed({3'b0, c_r}) + $signed({3'b0, c_g});
        if (c_n > 11'sd3 * c_d) begin
            c_n = 11'sd6 * c_d - c_n;
        end
        if (c_n < 11'sd0) begin
            c_n = 11'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_zero <= (c_d <= 11'sd0);
            r1_n    <= c_n[8:0];
            r1_d    <= c_d[7:0];
            r1_m    <= (i_red < i_green) ? i_red : i_green;
            r1_ctx  <= i_ctx;
        end
    end

    // Stage 2: n*n and d*d
    logic r2_v, r2_zero;
    logic [17:0] r2_nn;
    logic [15:0] r2_dd;
    logic [15:0] r2_m;
    cszp_pkg::t_ctx r2_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_zero <= r1_zero;
            r2_nn   <= 18'(r1_n * r1_n);
            r2_dd   <= 16'(r1_d * r1_d);
            r2_m    <= r1_m;
            r2_ctx  <= r1_ctx;
        end
    end

    // Divider pipeline registers, slot 0 is loaded by stage 3
    logic            r_v   [NW+1];
    logic [NW-1:0]   r_quo [NW+1];
    logic [DW:0]     r_rem [NW+1];
    logic [NW-1:0]   r_num [NW+1];
    logic [DW-1:0]   r_den [NW+1];
    cszp_pkg::t_ctx  r_ctx [NW+1];

    // Stage 3: numerator m*n*n scaled by 4096 into the divider's first slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r2_v;
        end
        if (i_en) begin
            r_num[0] <= r2_zero ? '0 :
                NW'({34'(r2_m * r2_nn), {cszp_pkg::FRAC_BITS{1'b0}}});
            r_den[0] <= r2_zero ? DW'(1) : r2_dd;
            r_ctx[0] <= r2_ctx;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
        end
    end

    // Divider pipeline: one quotient bit per stage, MSB first
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DW+1:0] c_t;
        logic [DW:0]   c_rem;
        logic [NW-1:0] c_quo;
        always_comb begin
            c_t   = {r_rem[k], r_num[k][NW-1-k]};
            c_rem = (c_t >= {2'b0, r_den[k]}) ? (DW+1)'(c_t - {2'b0, r_den[k]})
                                             : c_t[DW:0];
            c_quo = r_quo[k];
            c_quo[NW-1-k] = (c_t >= {2'b0, r_den[k]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_quo[k+1] <= c_quo;
                r_rem[k+1] <= c_rem;
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
                r_ctx[k+1] <= r_ctx[k];
            end
        end
    end

    // Saturate to the score width
    assign o_valid         = r_v[NW];
    assign o_upd.ctx       = r_ctx[NW];
    assign o_upd.score     = (|r_quo[NW][NW-1:cszp_pkg::SCORE_W]) ? '1
                           : r_quo[NW][cszp_pkg::SCORE_W-1:0];

endmodule

// ===== rtl/cszp_store.sv =====
// ----------------------------------------------------------------------------
// cszp_store
// Per-pixel best score and plane store: read, compare, write back, with
// forwarding of the last write to a following read of the same pixel.
// ----------------------------------------------------------------------------
module cszp_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_bright,
    input  logic                          i_valid,
    input  cszp_pkg::t_upd                i_upd,
    output logic                          o_valid,
    output logic [cszp_pkg::SCORE_W-1:0]  o_score,
    output logic [cszp_pkg::PLANE_W-1:0]  o_plane,
    output logic [cszp_pkg::PIX_W-1:0]    o_pix
);

    localparam int unsigned SW = cszp_pkg::SCORE_W;
    localparam int unsigned PW = cszp_pkg::PLANE_W;
    localparam int unsigned EW = cszp_pkg::ENTRY_W;

    // Read stage: issue the read and register the item alongside the read data
    logic           r_v;
    cszp_pkg::t_upd r_upd;
    logic [EW-1:0]  c_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_upd <= i_upd;
        end
    end

    // Forward the last write when it hits the pixel being updated
    logic          r_wv;
    logic [15:0]   r_wpix;
    logic [EW-1:0] r_wdata;
    logic [EW-1:0] c_old, c_new;
    logic          c_take, c_we;
    logic [SW-1:0] c_old_score;

    always_comb begin
        c_old       = (r_wv && r_wpix == r_upd.ctx.pix) ? r_wdata : c_rdata;
        c_old_score = c_old[EW-1:PW];
        if (r_upd.ctx.plane == '0) begin
            c_take = 1'b1;
        end else if (i_bright) begin
            c_take = r_upd.score < c_old_score;
        end else begin
            c_take = r_upd.score > c_old_score;
        end
        c_we  = i_en && r_v && c_take;
        c_new = c_take ? {r_upd.score, r_upd.ctx.plane} : c_old;
    end

    // Write-back record, also the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else if (i_en) begin
            r_wv <= r_v;
        end
        if (i_en) begin
            r_wpix  <= r_upd.ctx.pix;
            r_wdata <= c_new;
        end
    end

    cszp_ram #(.WIDTH(EW), .DEPTH(cszp_pkg::PIXELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_upd.ctx.pix),
        .i_wdata (c_new),
        .i_re    (i_en),
        .i_raddr (i_upd.ctx.pix),
        .o_rdata (c_rdata)
    );

    assign o_valid = r_wv;
    assign o_score = r_wdata[EW-1:PW];
    assign o_plane = r_wdata[PW-1:0];
    assign o_pix   = r_wpix;

endmodule

// ===== rtl/color_score_z_projection.sv =====
// ----------------------------------------------------------------------------
// color_score_z_projection
// Hue weighted z projection with a per-pixel depth map.
//
//   channel  | handshake                      | payload
//   input    | i_valid / o_ready              | i_red i_green i_blue i_pixel_index
//            |                                |   i_plane_index
//   result   | o_valid / i_ready              | o_best_score o_best_plane
//            |                                |   o_out_pixel_index
//   config   | i_cfg_valid / o_cfg_ready      | i_cfg_data (bit 0: bright bg)
//
// One item per cycle while results are taken; 3 arithmetic stages,
// 53 divider stages, store read and write-back.
// The whole pipeline advances together; a stalled result freezes it and
// o_ready falls only while the output is full and not taken.
// Reset clears valids and the register; store entries are valid once written
// at plane 0. No clearing pass.
// ----------------------------------------------------------------------------
module color_score_z_projection (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_red,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_green,
    input  logic [cszp_pkg::SAMPLE_W-1:0] i_blue,
    input  logic [cszp_pkg::PIX_W-1:0]    i_pixel_index,
    input  logic [cszp_pkg::PLANE_W-1:0]  i_plane_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cszp_pkg::SCORE_W-1:0]  o_best_score,
    output logic [cszp_pkg::PLANE_W-1:0]  o_best_plane,
    output logic [cszp_pkg::PIX_W-1:0]    o_out_pixel_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);

    logic r_bright;
    logic c_en;
    logic s_valid;
    cszp_pkg::t_upd s_upd;
    cszp_pkg::t_ctx c_ctx;

    // Advance the pipeline unless a result is waiting
    assign c_en        = !o_valid || i_ready;
    assign o_ready     = c_en;
    assign o_cfg_ready = 1'b1;
    assign c_ctx.pix   = i_pixel_index;
    assign c_ctx.plane = i_plane_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= 1'b0;
        end else if (i_cfg_valid) begin
            r_bright <= i_cfg_data;
        end
    end

    cszp_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_ctx   (c_ctx),
        .o_valid (s_valid),
        .o_upd   (s_upd)
    );

    cszp_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (c_en),
        .i_bright (r_bright),
        .i_valid  (s_valid),
        .i_upd    (s_upd),
        .o_valid  (o_valid),
        .o_score  (o_best_score),
        .o_plane  (o_best_plane),
        .o_pix    (o_out_pixel_index)
    );

endmodule

// ===== rtl/cszp_checker.sv =====
// ----------------------------------------------------------------------------
// cszp_checker
// Port level checks for the color score z projection block.
// ----------------------------------------------------------------------------
module cszp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_out_pixel_index,
    input logic        o_cfg_ready
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_pixel_index))
        else $error("stalled result changed");

    // Accept input whenever the output is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // Stall input only behind a waiting result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without cause");

    // Config always taken
    a_cfg: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config not ready");

endmodule

bind color_score_z_projection cszp_checker u_cszp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_out_pixel_index (o_out_pixel_index),
    .o_cfg_ready       (o_cfg_ready)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for color_score_z_projection. A directed table covers
// score extremes, ties and plane/pixel extremes. Random projections follow,
// plane 0 first and later planes over the same pixels, under both background
// settings. A local hue score and depth map store predict each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 70;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [cszp_pkg::SCORE_W-1:0] score;
        logic [cszp_pkg::PLANE_W-1:0] plane;
        logic [cszp_pkg::PIX_W-1:0]   pix;
    } t_result;

    typedef struct {
        logic [cszp_pkg::SAMPLE_W-1:0] red;
        logic [cszp_pkg::SAMPLE_W-1:0] green;
        logic [cszp_pkg::SAMPLE_W-1:0] blue;
        logic [cszp_pkg::PIX_W-1:0]    pix;
        logic [cszp_pkg::PLANE_W-1:0]  plane;
        bit                            typed;
        logic [cszp_pkg::SCORE_W-1:0]  score;
        logic [cszp_pkg::PLANE_W-1:0]  best;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [cszp_pkg::SAMPLE_W-1:0] i_red = '0;
    logic [cszp_pkg::SAMPLE_W-1:0] i_green = '0;
    logic [cszp_pkg::SAMPLE_W-1:0] i_blue = '0;
    logic [cszp_pkg::PIX_W-1:0]    i_pixel_index = '0;
    logic [cszp_pkg::PLANE_W-1:0]  i_plane_index = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [cszp_pkg::SCORE_W-1:0]  o_best_score;
    logic [cszp_pkg::PLANE_W-1:0]  o_best_plane;
    logic [cszp_pkg::PIX_W-1:0]    o_out_pixel_index;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic                          i_cfg_data = 1'b0;

    // Predictor state: kept score and depth per pixel, and which were written
    logic [cszp_pkg::SCORE_W-1:0] kept_score [cszp_pkg::PIXELS];
    logic [cszp_pkg::PLANE_W-1:0] kept_plane [cszp_pkg::PIXELS];
    bit                           pix_written [cszp_pkg::PIXELS];
    bit                           keep_min = 1'b0;

    t_result pending_results [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      calm = 1'b0;

    color_score_z_projection DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hue weighted score, 12 fraction bits
    function automatic logic [cszp_pkg::SCORE_W-1:0] hue_score(
            logic [cszp_pkg::SAMPLE_W-1:0] r,
            logic [cszp_pkg::SAMPLE_W-1:0] g,
            logic [cszp_pkg::SAMPLE_W-1:0] b);
        longint rc, gc, bc, d, n;
        longint unsigned m, num, q;
        rc = (r > 255) ? 255 : r;
        gc = (g > 255) ? 255 : g;
        bc = (b > 255) ? 255 : b;
        d  = ((rc > gc) ? rc : gc) - bc;
        if (d <= 0) return '0;
        n = d - rc + gc;
        if (n > 3 * d) n = 6 * d - n;
        if (n < 0) n = 0;
        m   = (r < g) ? r : g;
        num = m * longint'(n) * longint'(n) * 4096;
        q   = num / longint'(d * d);
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        return q[cszp_pkg::SCORE_W-1:0];
    endfunction

    // Update the depth map for one accepted item, return the kept entry
    function automatic t_result project_pixel(logic [cszp_pkg::SAMPLE_W-1:0] r,
                                              logic [cszp_pkg::SAMPLE_W-1:0] g,
                                              logic [cszp_pkg::SAMPLE_W-1:0] b,
                                              logic [cszp_pkg::PIX_W-1:0] pix,
                                              logic [cszp_pkg::PLANE_W-1:0] plane);
        logic [cszp_pkg::SCORE_W-1:0] s;
        bit                           take;
        s = hue_score(r, g, b);
        if (plane == 0) take = 1'b1;
        else if (keep_min) take = s < kept_score[pix];
        else take = s > kept_score[pix];
        if (take) begin
            kept_score[pix]  = s;
            kept_plane[pix]  = plane;
            pix_written[pix] = 1'b1;
        end
        return '{kept_score[pix], kept_plane[pix], pix};
    endfunction

    // Input side idling
    task automatic idle_input();
        while (!calm && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drive one item, wait for it to be taken, queue its expected result
    task automatic send_pixel(t_row row);
        t_result exp_res;
        idle_input();
        i_valid       <= 1'b1;
        i_red         <= row.red;
        i_green       <= row.green;
        i_blue        <= row.blue;
        i_pixel_index <= row.pix;
        i_plane_index <= row.plane;
        do @(posedge i_clk); while (!o_ready);
        exp_res = project_pixel(row.red, row.green, row.blue, row.pix, row.plane);
        if (row.typed) exp_res = '{row.score, row.best, row.pix};
        pending_results.push_back(exp_res);
    endtask

    // Drain the pipeline, then write the background mode
    task automatic write_mode(bit mode);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        keep_min = mode;
    endtask

    function automatic logic [cszp_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 16'($urandom_range(255));
        if (sel < 90) return 16'($urandom_range(65535));
        case ($urandom_range(2))
            0: return 16'd0;
            1: return 16'd255;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic t_row random_row(logic [cszp_pkg::PIX_W-1:0] pix,
                                        logic [cszp_pkg::PLANE_W-1:0] plane);
        t_row row;
        row.red   = pick_sample();
        row.green = pick_sample();
        row.blue  = pick_sample();
        row.pix   = pix;
        row.plane = plane;
        row.typed = 1'b0;
        row.score = '0;
        row.best  = '0;
        return row;
    endfunction

    // One projection: plane 0 over a pixel group, then later planes
    task automatic run_projection(inout int sent);
        logic [cszp_pkg::PIX_W-1:0]   base;
        logic [cszp_pkg::PLANE_W-1:0] plane;
        t_row                         row, prev;
        int                           npix, nplanes;
        base    = 16'($urandom_range(65535));
        npix    = $urandom_range(1, 8);
        nplanes = $urandom_range(1, 6);
        for (int p = 0; p <= nplanes; p++) begin
            plane = (p == nplanes && $urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                                              : 10'(p);
            if (p == 0) plane = '0;
            for (int k = 0; k < npix; k++) begin
                row = random_row(16'(base + $urandom_range(npix - 1)), plane);
                if (p == 0) row.pix = 16'(base + k);
                // repeat the previous colors now and then to hit ties
                if (k > 0 && $urandom_range(9) == 0) begin
                    row.red = prev.red; row.green = prev.green; row.blue = prev.blue;
                end
                send_pixel(row);
                prev = row;
                sent++;
            end
        end
    endtask

    // Noise: fresh pixels at plane 0, or known pixels at any plane
    task automatic send_noise(inout int sent);
        logic [cszp_pkg::PIX_W-1:0] pix;
        pix = 16'($urandom_range(65535));
        if (pix_written[pix]) send_pixel(random_row(pix, 10'($urandom_range(1023))));
        else send_pixel(random_row(pix, '0));
        sent++;
    endtask

    t_row directed [18] = '{
        '{16'd0,     16'd0,     16'd0,     16'd0,     10'd0,    1, 32'd0,         10'd0},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd1,     10'd0,    1, 32'd0,         10'd0},
        '{16'd255,   16'd0,     16'd0,     16'd2,     10'd0,    1, 32'd0,         10'd0},
        '{16'd0,     16'd255,   16'd0,     16'd3,     10'd0,    1, 32'd0,         10'd0},
        '{16'd255,   16'd255,   16'd0,     16'd4,     10'd0,    1, 32'd1044480,   10'd0},
        '{16'hFFFF,  16'hFFFF,  16'd0,     16'hFFFF,  10'd0,    1, 32'd268431360, 10'd0},
        '{16'd1,     16'd255,   16'd128,   16'd5,     10'd0,    1, 32'd36864,     10'd0},
        '{16'd255,   16'hFFFF,  16'd300,   16'd6,     10'd0,    1, 32'd0,         10'd0},
        '{16'd200,   16'd100,   16'd50,    16'd4,     10'd1,    0, 32'd0,         10'd0},
        '{16'd255,   16'd255,   16'd0,     16'd4,     10'd2,    0, 32'd0,         10'd0},
        '{16'hFFFF,  16'hFFFF,  16'd0,     16'hFFFF,  10'd1023, 0, 32'd0,         10'd0},
        '{16'd40000, 16'd30000, 16'd10,    16'hFFFF,  10'd1022, 0, 32'd0,         10'd0},
        '{16'd100,   16'd200,   16'd0,     16'd0,     10'd1,    0, 32'd0,         10'd0},
        '{16'd0,     16'd0,     16'd0,     16'd0,     10'd2,    0, 32'd0,         10'd0},
        '{16'd30,    16'd20,    16'd10,    16'd5,     10'd3,    0, 32'd0,         10'd0},
        '{16'hAAAA,  16'h5555,  16'h1234,  16'd2,     10'd7,    0, 32'd0,         10'd0},
        '{16'd128,   16'd64,    16'd200,   16'd3,     10'd512,  0, 32'd0,         10'd0},
        '{16'd255,   16'd254,   16'd0,     16'd1,     10'd1,    0, 32'd0,         10'd0}
    };

    // Output side idling, with a calm stretch
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 38);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: score %h plane %0d pix %0d",
                             o_best_score, o_best_plane, o_out_pixel_index);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_best_score !== exp_res.score || o_best_plane !== exp_res.plane ||
                    o_out_pixel_index !== exp_res.pix) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 exp_res.score, exp_res.plane, exp_res.pix,
                                 o_best_score, o_best_plane, o_out_pixel_index);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        bit modes [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows in default mode
        write_mode(1'b0);
        foreach (directed[i]) send_pixel(directed[i]);

        // Random projections, one phase per background mode
        foreach (modes[ph]) begin
            write_mode(modes[ph]);
            sent = 0;
            while (sent < 420) begin
                calm = (ph == 2 && sent > 100 && sent < 300);
                if ($urandom_range(99) < 85) run_projection(sent);
                else send_noise(sent);
            end
            calm = 1'b0;
        end

        // Drain and report
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
